// ===== rtl/core/lr3_pkg.sv =====
`default_nettype none

package lr3_pkg;

    // axis that advances on every voxel
    typedef enum logic [1:0] {
        AX_X = 2'd0,
        AX_Y = 2'd1,
        AX_Z = 2'd2
    } t_axis;

    typedef enum logic {
        WK_IDLE = 1'b0,
        WK_RUN  = 1'b1
    } t_walk_state;

    // segment queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    // descriptor bits: position, three errors, three doubled deltas,
    // step signs, driving axis, driving step count
    function automatic int desc_bits(input int cb);
        return 3 * cb + 3 * (cb + 3) + 3 * (cb + 1) + 3 + 2 + cb;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/lr3_front.sv =====
`default_nettype none

module lr3_front #(
    parameter int COORD_BITS = 6
) (
    input  wire logic                                          i_valid,
    input  wire logic [COORD_BITS-1:0]                         i_start_x,
    input  wire logic [COORD_BITS-1:0]                         i_start_y,
    input  wire logic [COORD_BITS-1:0]                         i_start_z,
    input  wire logic [COORD_BITS-1:0]                         i_end_x,
    input  wire logic [COORD_BITS-1:0]                         i_end_y,
    input  wire logic [COORD_BITS-1:0]                         i_end_z,
    input  wire lr3_pkg::t_q_status                            i_q_status,
    output logic                                               o_stall,
    output logic                                               o_push,
    output logic [lr3_pkg::desc_bits(COORD_BITS)-1:0]          o_desc
);
    import lr3_pkg::*;

    localparam int CB = COORD_BITS;
    localparam int EB = COORD_BITS + 3;

    typedef struct packed {
        logic [2:0][CB-1:0] pos;
        logic [2:0][EB-1:0] err;
        logic [2:0][CB:0]   dd;
        logic [2:0]         sgn;
        t_axis              axis;
        logic [CB-1:0]      steps;
    } t_desc;

    logic [2:0][CB-1:0] start_c;
    logic [2:0][CB-1:0] end_c;
    logic [2:0][CB:0]   delta;
    logic [2:0][CB:0]   neg_delta;
    logic [2:0][CB-1:0] absd;
    logic [CB-1:0]      abs_drv;
    t_desc              desc;

    assign start_c = {i_start_z, i_start_y, i_start_x};
    assign end_c   = {i_end_z, i_end_y, i_end_x};

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            delta[a]     = {end_c[a][CB-1], end_c[a]} - {start_c[a][CB-1], start_c[a]};
            neg_delta[a] = (CB+1)'(0) - delta[a];
            absd[a]      = delta[a][CB] ? neg_delta[a][CB-1:0] : delta[a][CB-1:0];
        end
    end

    // driving axis: x wins ties, then y
    always_comb begin
        desc.pos  = start_c;
        desc.axis = AX_Z;
        if (absd[0] >= absd[1] && absd[0] >= absd[2]) begin
            desc.axis = AX_X;
        end else if (absd[1] >= absd[0] && absd[1] >= absd[2]) begin
            desc.axis = AX_Y;
        end
        abs_drv    = absd[desc.axis];
        desc.steps = abs_drv;
        for (int a = 0; a < 3; a++) begin
            desc.sgn[a] = delta[a][CB];
            desc.dd[a]  = {absd[a], 1'b0};
            // driving axis slot is held but never used by the walker
            desc.err[a] = {2'b00, absd[a], 1'b0} - {3'b000, abs_drv};
        end
    end

    assign o_stall = i_q_status.full;
    assign o_push  = i_valid && !i_q_status.full;
    assign o_desc  = desc;

endmodule

`default_nettype wire

// ===== rtl/core/lr3_queue.sv =====
`default_nettype none

module lr3_queue #(
    parameter int WIDTH = 8
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire logic [WIDTH-1:0]   i_data,
    input  wire logic               i_pop,
    output logic [WIDTH-1:0]        o_data,
    output lr3_pkg::t_q_status      o_status
);
    import lr3_pkg::*;

    // two-entry ring
    logic [WIDTH-1:0] r_mem [2];
    logic             r_wr_ptr;
    logic             r_rd_ptr;
    logic [1:0]       r_count;
    logic [1:0]       n_count;

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_data         = r_mem[r_rd_ptr];
    assign o_status.full  = r_count[1];
    assign o_status.empty = (r_count == 2'd0);

endmodule

`default_nettype wire

// ===== rtl/core/lr3_walk.sv =====
`default_nettype none

module lr3_walk #(
    parameter int COORD_BITS = 6
) (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_rst_n,
    input  wire lr3_pkg::t_q_status                       i_q_status,
    input  wire logic [lr3_pkg::desc_bits(COORD_BITS)-1:0] i_desc,
    output logic                                          o_pop,
    output logic                                          o_valid,
    input  wire logic                                     i_stall,
    output logic [COORD_BITS-1:0]                         o_voxel_x,
    output logic [COORD_BITS-1:0]                         o_voxel_y,
    output logic [COORD_BITS-1:0]                         o_voxel_z,
    output logic                                          o_last_voxel
);
    import lr3_pkg::*;

    localparam int CB = COORD_BITS;
    localparam int EB = COORD_BITS + 3;

    typedef struct packed {
        logic [2:0][CB-1:0] pos;
        logic [2:0][EB-1:0] err;
        logic [2:0][CB:0]   dd;
        logic [2:0]         sgn;
        t_axis              axis;
        logic [CB-1:0]      steps;
    } t_desc;

    t_desc              desc;
    t_walk_state        r_state;
    t_walk_state        n_state;
    logic [2:0][CB-1:0] r_pos;
    logic [2:0][EB-1:0] r_err;
    logic [2:0][CB:0]   r_dd;
    logic [2:0]         r_sgn;
    t_axis              r_axis;
    logic [CB-1:0]      r_steps;
    logic [2:0][CB-1:0] n_pos;
    logic [2:0][EB-1:0] n_err;
    logic [CB:0]        dd_drv;
    logic               at_end;
    logic               can_load;
    logic               emit;
    logic               r_out_valid;
    logic [2:0][CB-1:0] r_out_pos;
    logic               r_out_last;

    assign desc     = i_desc;
    assign at_end   = (r_steps == '0);
    assign can_load = !r_out_valid || !i_stall;
    assign dd_drv   = r_dd[r_axis];

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            WK_IDLE: begin
                if (!i_q_status.empty) begin
                    n_state = WK_RUN;
                end
            end
            WK_RUN: begin
                if (can_load && at_end) begin
                    n_state = WK_IDLE;
                end
            end
            default: n_state = WK_IDLE;
        endcase
    end

    always_comb begin
        o_pop = 1'b0;
        emit  = 1'b0;
        unique case (r_state)
            WK_IDLE: o_pop = !i_q_status.empty;
            WK_RUN:  emit  = can_load;
            default: begin
                o_pop = 1'b0;
                emit  = 1'b0;
            end
        endcase
    end

    // one Bresenham step; minor axes are independent
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            n_pos[a] = r_pos[a];
            n_err[a] = r_err[a] + {2'b00, r_dd[a]};
            if (r_axis == t_axis'(a)) begin
                n_pos[a] = r_pos[a] + (r_sgn[a] ? {CB{1'b1}} : CB'(1));
                n_err[a] = r_err[a];
            end else if (!r_err[a][EB-1] && r_err[a] != '0) begin
                n_pos[a] = r_pos[a] + (r_sgn[a] ? {CB{1'b1}} : CB'(1));
                n_err[a] = r_err[a] - {2'b00, dd_drv} + {2'b00, r_dd[a]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= WK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_pos   <= desc.pos;
            r_err   <= desc.err;
            r_dd    <= desc.dd;
            r_sgn   <= desc.sgn;
            r_axis  <= desc.axis;
            r_steps <= desc.steps;
        end else if (emit && !at_end) begin
            r_pos   <= n_pos;
            r_err   <= n_err;
            r_steps <= r_steps - CB'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_pos  <= r_pos;
            r_out_last <= at_end;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_voxel_x    = r_out_pos[0];
    assign o_voxel_y    = r_out_pos[1];
    assign o_voxel_z    = r_out_pos[2];
    assign o_last_voxel = r_out_last;

endmodule

`default_nettype wire

// ===== rtl/core/line_rasterizer_3d.sv =====
`default_nettype none

// Channel   Direction  Handshake                  Word
// segment   in         i_in_valid / o_in_stall    start_x/y/z, end_x/y/z
// voxel     out        o_out_valid / i_out_stall  voxel_x/y/z, last_voxel
//
// A segment is unloaded from the queue while the walker is idle; the walker
// then emits its driving delta + 1 voxels, up to 2^COORD_BITS, one at a time,
// holding while the output register is full and stalled.
// Reset is synchronous, active low; it empties the queue and the output.
// The front takes segments while the two-deep queue has room, so it keeps
// accepting while the walker sits stalled on a full output register.

module line_rasterizer_3d #(
    parameter int COORD_BITS = 6
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // segment in
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic [COORD_BITS-1:0] i_start_x,
    input  wire logic [COORD_BITS-1:0] i_start_y,
    input  wire logic [COORD_BITS-1:0] i_start_z,
    input  wire logic [COORD_BITS-1:0] i_end_x,
    input  wire logic [COORD_BITS-1:0] i_end_y,
    input  wire logic [COORD_BITS-1:0] i_end_z,
    // voxel out
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic [COORD_BITS-1:0]      o_voxel_x,
    output logic [COORD_BITS-1:0]      o_voxel_y,
    output logic [COORD_BITS-1:0]      o_voxel_z,
    output logic                       o_last_voxel
);
    import lr3_pkg::*;

    localparam int DescBits = desc_bits(COORD_BITS);

    logic                push;
    logic                pop;
    logic [DescBits-1:0] front_desc;
    logic [DescBits-1:0] queue_desc;
    t_q_status           q_status;

    // front: deltas, magnitudes, driving axis, starting error terms
    lr3_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_valid    (i_in_valid),
        .i_start_x  (i_start_x),
        .i_start_y  (i_start_y),
        .i_start_z  (i_start_z),
        .i_end_x    (i_end_x),
        .i_end_y    (i_end_y),
        .i_end_z    (i_end_z),
        .i_q_status (q_status),
        .o_stall    (o_in_stall),
        .o_push     (push),
        .o_desc     (front_desc)
    );

    // segment descriptors waiting for the walker
    lr3_queue #(
        .WIDTH (DescBits)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_data   (front_desc),
        .i_pop    (pop),
        .o_data   (queue_desc),
        .o_status (q_status)
    );

    // back: one voxel per cycle, when not stalled, into a registered output stage
    lr3_walk #(
        .COORD_BITS (COORD_BITS)
    ) u_walk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_status   (q_status),
        .i_desc       (queue_desc),
        .o_pop        (pop),
        .o_valid      (o_out_valid),
        .i_stall      (i_out_stall),
        .o_voxel_x    (o_voxel_x),
        .o_voxel_y    (o_voxel_y),
        .o_voxel_z    (o_voxel_z),
        .o_last_voxel (o_last_voxel)
    );

endmodule

`default_nettype wire
